// ===== hdl/dcss_pkg.sv =====
// Package for the duty-cycled servo sweep controller: modes, sequencer states and constants.
package dcss_pkg;

  localparam logic [31:0] WORK_TIME_RESET  = 32'd60000;
  localparam logic [31:0] SLEEP_TIME_RESET = 32'd10000;
  localparam logic [7:0]  FULL_ANGLE       = 8'd180;

  localparam int          CFG_INDEX_W    = 8;
  localparam logic [7:0]  REG_WORK_TIME  = 8'd0;
  localparam logic [7:0]  REG_SLEEP_TIME = 8'd1;

  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_SLEEP  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } seq_state_t;

endpackage

// ===== hdl/duty_cycled_servo_sweep_controller.sv =====
// Duty-cycled servo sweep controller: tick decoder, serial angle divider and result register.
//
// Each input word on the s_ channel is one scheduler tick. The block decides its mode
// (closed, open or sleeping) from the tick time and the work and sleep times, and while
// open it steps a sweep counter and scales it to an angle of step*180/speed degrees.
// One result word leaves on the m_ channel for every input word, in order.
// The cfg channel writes the work time (index 0) and sleep time (index 1); it is always
// ready and other indices are ignored.
// Timing: a tick that commands an angle runs a restoring divider, one quotient bit a
// cycle, and its result is offered once the divider is done; any other tick gives its
// result on the next cycle. The block takes one word at a time: it accepts no new tick
// until the result of the last one has been taken, so any output stall holds it too.
// While the receiver holds m_tready low, the result word is held and s_tready stays low.
// Reset puts the block in the closed mode with the servo off, the sweep counter at zero
// and rising, both time marks at zero and the registers at 60000 ms and 10000 ms.
module duty_cycled_servo_sweep_controller
  import dcss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [47:0]            s_tdata,   // now_ms[31:0], open_request[32], sweep_speed[40:33]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,   // servo_enable[0], angle_valid[1],
                                            // servo_angle[9:2], sleeping[10]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic [31:0] now_ms;
  logic        open_request;
  logic [7:0]  sweep_speed;

  logic [31:0] work_time_ms;
  logic [31:0] sleep_time_ms;

  seq_state_t  state;
  seq_state_t  state_next;

  mode_t       mode;
  mode_t       mode_next;
  logic        resume_open;
  logic        resume_open_next;
  logic [31:0] last_wake_ms;
  logic [31:0] last_wake_ms_next;
  logic [31:0] sleep_start_ms;
  logic [31:0] sleep_start_ms_next;
  logic [7:0]  sweep_step;
  logic [7:0]  sweep_step_next;
  logic [7:0]  sweep_total;
  logic [7:0]  sweep_total_next;
  logic        sweep_rising;
  logic        sweep_rising_next;
  logic        servo_on;
  logic        servo_on_next;
  logic        need_div;

  logic [31:0] elapsed;
  logic [31:0] limit;
  logic        expired;
  logic        turn_rising;

  logic [DIV_W-1:0]     div_quot;
  logic [8:0]           div_rem;
  logic [7:0]           div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [8:0]           rem_shift;
  logic                 rem_ge;
  logic [8:0]           rem_next;
  logic [DIV_W-1:0]     quot_next;
  logic [DIV_W-1:0]     product;

  logic        res_enable;
  logic        res_valid;
  logic [7:0]  res_angle;
  logic        res_sleeping;

  logic        in_accept;
  logic        out_accept;
  logic        div_last;

  assign now_ms       = s_tdata[31:0];
  assign open_request = s_tdata[32];
  assign sweep_speed  = s_tdata[40:33];

  assign in_accept  = s_tvalid && s_tready;
  assign out_accept = m_tvalid && m_tready;
  assign div_last   = (div_cnt == {DIV_CNT_W{1'b1}});
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_time_ms  <= WORK_TIME_RESET;
      sleep_time_ms <= SLEEP_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WORK_TIME:  work_time_ms  <= cfg_data;
        REG_SLEEP_TIME: sleep_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick decoder: one modular subtract and compare, then the mode update.
  always_comb begin
    elapsed = now_ms - ((mode == MODE_SLEEP) ? sleep_start_ms : last_wake_ms);
    limit   = (mode == MODE_SLEEP) ? sleep_time_ms : work_time_ms;
    expired = (elapsed >= limit);

    mode_next           = mode;
    resume_open_next    = resume_open;
    last_wake_ms_next   = last_wake_ms;
    sleep_start_ms_next = sleep_start_ms;
    sweep_step_next     = sweep_step;
    sweep_total_next    = sweep_total;
    sweep_rising_next   = sweep_rising;
    servo_on_next       = servo_on;
    need_div            = 1'b0;
    turn_rising         = sweep_rising;

    case (mode)
      MODE_SLEEP: begin
        if (expired) begin
          last_wake_ms_next = now_ms;
          mode_next = resume_open ? MODE_OPEN : MODE_CLOSED;
        end
      end
      MODE_OPEN: begin
        if (expired) begin
          resume_open_next    = 1'b1;
          mode_next           = MODE_SLEEP;
          sleep_start_ms_next = now_ms;
        end else if (!open_request || sweep_speed == 8'd0) begin
          servo_on_next = 1'b0;
          mode_next     = MODE_CLOSED;
        end else begin
          sweep_total_next = sweep_speed;
          if (sweep_rising && sweep_step >= sweep_speed) begin
            turn_rising = 1'b0;
          end else if (!sweep_rising && sweep_step == 8'd0) begin
            turn_rising = 1'b1;
          end
          sweep_rising_next = turn_rising;
          sweep_step_next   = turn_rising ? sweep_step + 8'd1 : sweep_step - 8'd1;
          need_div          = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_CLOSED;
        if (expired) begin
          resume_open_next    = 1'b0;
          mode_next           = MODE_SLEEP;
          sleep_start_ms_next = now_ms;
        end else if (open_request) begin
          sweep_step_next  = 8'd0;
          sweep_total_next = sweep_speed;
          servo_on_next    = 1'b1;
          mode_next        = MODE_OPEN;
        end
      end
    endcase

    product = {1'b0, sweep_step_next, 7'd0} + {3'd0, sweep_step_next, 5'd0}
            + {4'd0, sweep_step_next, 4'd0} + {6'd0, sweep_step_next, 2'd0};
  end

  // Restoring divider step: one quotient bit a cycle.
  always_comb begin
    rem_shift = {div_rem[7:0], div_quot[DIV_W-1]};
    rem_ge    = (rem_shift >= {1'b0, div_den});
    rem_next  = rem_ge ? rem_shift - {1'b0, div_den} : rem_shift;
    quot_next = {div_quot[DIV_W-2:0], rem_ge};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = need_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_accept) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_DONE);
    m_tdata  = {5'd0, res_sleeping, res_angle, res_valid, res_enable};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode           <= MODE_CLOSED;
      resume_open    <= 1'b0;
      last_wake_ms   <= 32'd0;
      sleep_start_ms <= 32'd0;
      sweep_step     <= 8'd0;
      sweep_total    <= 8'd0;
      sweep_rising   <= 1'b1;
      servo_on       <= 1'b0;
      div_cnt        <= '0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        mode           <= mode_next;
        resume_open    <= resume_open_next;
        last_wake_ms   <= last_wake_ms_next;
        sleep_start_ms <= sleep_start_ms_next;
        sweep_step     <= sweep_step_next;
        sweep_total    <= sweep_total_next;
        sweep_rising   <= sweep_rising_next;
        servo_on       <= servo_on_next;
        div_cnt        <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      div_quot     <= product;
      div_rem      <= 9'd0;
      div_den      <= sweep_total_next;
      res_enable   <= servo_on_next;
      res_valid    <= need_div;
      res_angle    <= 8'd0;
      res_sleeping <= (mode_next == MODE_SLEEP);
    end else if (state == ST_DIV) begin
      div_quot <= quot_next;
      div_rem  <= rem_next;
      if (div_last) begin
        res_angle <= (quot_next > {8'd0, FULL_ANGLE}) ? FULL_ANGLE : quot_next[7:0];
      end
    end
  end

endmodule

// ===== tb/servo_tick_checker.sv =====
// Checker for the servo sweep controller: predicts the result word of every tick and compares.
module servo_tick_checker
  import dcss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [47:0]            s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [15:0]            m_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     failures,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       sleeping;
    logic [7:0] servo_angle;
    logic       angle_valid;
    logic       servo_enable;
  } tick_result_t;

  logic [31:0]  work_ms;
  logic [31:0]  sleep_ms;
  logic [31:0]  wake_ms;
  logic [31:0]  nap_start_ms;
  mode_t        mode;
  mode_t        resume_mode;
  logic [7:0]   step;
  logic [7:0]   total;
  logic         rising;
  logic         servo_on;
  tick_result_t expected_ticks[$];

  function automatic void start_nap(input logic [31:0] now_ms, input mode_t from);
    resume_mode  = from;
    mode         = MODE_SLEEP;
    nap_start_ms = now_ms;
  endfunction

  function automatic tick_result_t advance_servo(input logic [31:0] now_ms,
                                                 input logic        open_req,
                                                 input logic [7:0]  speed);
    tick_result_t r;
    int unsigned  scaled;
    r = '0;
    case (mode)
      MODE_SLEEP: begin
        if (now_ms - nap_start_ms >= sleep_ms) begin
          wake_ms = now_ms;
          mode    = resume_mode;
        end
      end
      MODE_OPEN: begin
        if (now_ms - wake_ms >= work_ms) begin
          start_nap(now_ms, MODE_OPEN);
        end else if (!open_req || speed == 8'd0) begin
          servo_on = 1'b0;
          mode     = MODE_CLOSED;
        end else begin
          total = speed;
          if (rising && step >= total) rising = 1'b0;
          else if (!rising && step == 8'd0) rising = 1'b1;
          step = rising ? step + 8'd1 : step - 8'd1;
          scaled = (32'(step) * 32'(FULL_ANGLE)) / 32'(total);
          r.servo_angle = (scaled > 32'(FULL_ANGLE)) ? FULL_ANGLE : scaled[7:0];
          r.angle_valid = 1'b1;
        end
      end
      default: begin
        mode = MODE_CLOSED;
        if (now_ms - wake_ms >= work_ms) begin
          start_nap(now_ms, MODE_CLOSED);
        end else if (open_req) begin
          step     = 8'd0;
          total    = speed;
          servo_on = 1'b1;
          mode     = MODE_OPEN;
        end
      end
    endcase
    r.servo_enable = servo_on;
    r.sleeping     = (mode == MODE_SLEEP);
    return r;
  endfunction

  function automatic void compare_field(input string field, input int want, input int got);
    if (want != got) begin
      failures++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (rst) begin
      work_ms      = WORK_TIME_RESET;
      sleep_ms     = SLEEP_TIME_RESET;
      wake_ms      = '0;
      nap_start_ms = '0;
      mode         = MODE_CLOSED;
      resume_mode  = MODE_CLOSED;
      step         = '0;
      total        = '0;
      rising       = 1'b1;
      servo_on     = 1'b0;
      expected_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WORK_TIME) work_ms = cfg_data;
        else if (cfg_index == REG_SLEEP_TIME) sleep_ms = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got = tick_result_t'(m_tdata[10:0]);
        if (expected_ticks.size() == 0) begin
          failures++;
          $display("%0t ns: result word expected none, got %h", $time, m_tdata);
        end else begin
          want = expected_ticks.pop_front();
          compare_field("servo_enable", int'(want.servo_enable), int'(got.servo_enable));
          compare_field("angle_valid", int'(want.angle_valid), int'(got.angle_valid));
          compare_field("servo_angle", int'(want.servo_angle), int'(got.servo_angle));
          compare_field("sleeping", int'(want.sleeping), int'(got.sleeping));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_ticks.push_back(advance_servo(s_tdata[31:0], s_tdata[32], s_tdata[40:33]));
      end
    end
    pending <= expected_ticks.size();
  end

endmodule

// ===== tb/duty_cycled_servo_sweep_controller_tb.sv =====
// Testbench top for the servo sweep controller: clock, reset, tick and register traffic, verdict.
module duty_cycled_servo_sweep_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcss_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] NO_SUCH_REG = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] LAST_INDEX  = '1;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [47:0]            s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [15:0]            m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_data;
  int                     failures;
  int                     pending;
  logic [31:0]            clock_ms;
  logic [7:0]             cur_speed;
  bit                     send_quiet;

  duty_cycled_servo_sweep_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  servo_tick_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("duty_cycled_servo_sweep_controller test failed");
    $finish;
  end

  // The receiver holds off for a long stretch once, so that the block fills and stalls its input.
  initial begin : receiver
    int gap;
    int taken;
    bit quiet;
    m_tready = 1'b0;
    taken    = 0;
    quiet    = 1'b0;
    forever begin
      if (taken % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (taken == 100) gap = 400;
      @(negedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_tick(input logic [31:0] now_ms, input logic open_req,
                           input logic [7:0] speed);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, speed, open_req, now_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained(input int extra);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(input logic [31:0] work_ms, input logic [31:0] nap_ms);
    wait_drained(24);
    write_reg(REG_WORK_TIME, work_ms);
    write_reg(REG_SLEEP_TIME, nap_ms);
  endtask

  // Time mostly creeps forward so that work and sleep periods run out; the speed is sticky
  // so that sweeps bounce between their ends.
  task automatic run_ticks(input int count, input int unsigned span, input int pause_at);
    logic open_req;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      if (i == pause_at) wait_drained(0);
      if ($urandom_range(0, 24) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, span);
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 5))
          0:       cur_speed = 8'd0;
          1, 2:    cur_speed = 8'($urandom_range(0, 255));
          default: cur_speed = 8'($urandom_range(1, 6));
        endcase
      end
      open_req = ($urandom_range(0, 11) != 0);
      send_tick(clock_ms, open_req, cur_speed);
    end
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    clock_ms   = '0;
    cur_speed  = 8'd3;
    send_quiet = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_tick(32'd0, 1'b0, 8'd0);
    send_tick(32'd10, 1'b1, 8'd3);
    send_tick(32'd20, 1'b1, 8'd3);
    send_tick(32'd30, 1'b1, 8'd3);
    send_tick(32'd40, 1'b1, 8'd3);
    // A lowered total while the step sits above it: the angle saturates.
    send_tick(32'd50, 1'b1, 8'd1);
    send_tick(32'd60, 1'b1, 8'd1);
    send_tick(32'd70, 1'b1, 8'd1);
    send_tick(32'd80, 1'b1, 8'd1);
    send_tick(32'd90, 1'b1, 8'd255);
    send_tick(32'd100, 1'b0, 8'd255);
    send_tick(32'd110, 1'b0, 8'd7);
    send_tick(32'd120, 1'b1, 8'd0);
    send_tick(32'd130, 1'b1, 8'd0);
    send_tick(32'd140, 1'b1, 8'd200);
    send_tick(32'd150, 1'b1, 8'd200);
    send_tick(32'd60000, 1'b1, 8'd200);
    send_tick(32'd65000, 1'b1, 8'd5);
    send_tick(32'd70000, 1'b0, 8'd5);
    send_tick(32'd70010, 1'b1, 8'd5);
    send_tick(32'hFFFF_FFFF, 1'b1, 8'd5);
    send_tick(32'h0000_2000, 1'b1, 8'd5);
    send_tick(32'd10000, 1'b0, 8'd5);
    send_tick(32'd10010, 1'b0, 8'd5);
    send_tick(32'd70010, 1'b0, 8'd0);
    clock_ms = 32'd80010;

    run_ticks(120, 2000, -1);
    reconfigure(32'd1, 32'd1);
    run_ticks(30, 3, -1);
    reconfigure(32'd0, 32'd0);
    run_ticks(25, 2, -1);
    reconfigure(32'd40, 32'd15);
    run_ticks(60, 6, 30);
    reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(NO_SUCH_REG, $urandom());
    write_reg(LAST_INDEX, $urandom());
    run_ticks(25, 1000, -1);
    reconfigure(32'd300, 32'd100);
    run_ticks(80, 30, 40);
    reconfigure(32'd1, 32'hFFFF_FFFF);
    run_ticks(20, 50, -1);
    reconfigure(32'd5000, 32'd1);
    run_ticks(40, 500, -1);
    wait_drained(40);

    if (failures == 0) begin
      $display("duty_cycled_servo_sweep_controller test passed");
    end else begin
      $display("duty_cycled_servo_sweep_controller test failed");
    end
    $finish;
  end

endmodule
